### rtl/bmp_rgb24_stream_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef BMP_RGB24_STREAM_DECODER_MACROS_SVH
`define BMP_RGB24_STREAM_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bmp_dec_pkg.sv
package bmp_dec_pkg;

   // Payload widths.
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int ERR_W   = 3;
   localparam int DIM_W   = 13;
   localparam int INDEX_W = 24;
   localparam int COLOR_W = 8;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FILE_SIZE = 1'b0;

   typedef logic [DIM_W-1:0]   dim_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [COLOR_W-1:0] color_type;

   // Result kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // Error codes.
   typedef enum logic [ERR_W-1:0] {
      ERR_SHORT      = 3'd0,
      ERR_SIGNATURE  = 3'd1,
      ERR_OFFSET_END = 3'd2,
      ERR_DIMENSIONS = 3'd3,
      ERR_DEPTH      = 3'd4,
      ERR_DATA_END   = 3'd5,
      ERR_OFFSET_HDR = 3'd6
   } err_type;

   // Stream phase.
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_PIXELS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   // Header check sequencer.
   typedef enum logic [2:0] {
      SEQ_RUN  = 3'b001,
      SEQ_SIZE = 3'b010,
      SEQ_BASE = 3'b100
   } seq_type;

   // Header byte positions.
   localparam logic [31:0] POS_SIG_B       = 32'd0;
   localparam logic [31:0] POS_SIG_M       = 32'd1;
   localparam logic [31:0] POS_OFFSET      = 32'd10;
   localparam logic [31:0] POS_OFFSET_END  = 32'd13;
   localparam logic [31:0] POS_WIDTH       = 32'd18;
   localparam logic [31:0] POS_WIDTH_END   = 32'd21;
   localparam logic [31:0] POS_HEIGHT      = 32'd22;
   localparam logic [31:0] POS_HEIGHT_END  = 32'd25;
   localparam logic [31:0] POS_DEPTH       = 32'd28;
   localparam logic [31:0] HEADER_LAST     = 32'd29;
   localparam logic [31:0] FIRST_PIXEL_POS = 32'd30;
   localparam logic [31:0] MIN_FILE_SIZE   = 32'd14;

   localparam logic [7:0]  SIG_B        = 8'h42;
   localparam logic [7:0]  SIG_M        = 8'h4D;
   localparam logic [15:0] DEPTH_RGB24  = 16'd24;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   // One result transaction.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ERR_W-1:0]  error_code;
      dim_type           image_width;
      dim_type           image_height;
      index_type         pixel_index;
      color_type         red;
      color_type         green;
      color_type         blue;
      color_type         alpha;
      logic              last_pixel;
   } rsp_type;

   // Register port request as seen by the register block.
   typedef struct packed {
      logic                  psel;
      logic                  penable;
      logic                  pwrite;
      logic [CSR_ADDR_W-1:0] paddr;
      logic [CSR_DATA_W-1:0] pwdata;
   } apb_req_type;

endpackage

### rtl/bmp_dec_ifs.sv
// Byte stream into the decoder.
interface bmp_dec_req_if;
   logic                             valid;
   logic                             ready;
   logic [bmp_dec_pkg::BYTE_W-1:0]   byte_value;
   logic                             end_of_file;

   modport source (output valid, byte_value, end_of_file, input ready);
   modport sink (input valid, byte_value, end_of_file, output ready);
endinterface

// Results out of the decoder.
interface bmp_dec_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bmp_dec_pkg::KIND_W-1:0]    kind;
   logic [bmp_dec_pkg::ERR_W-1:0]     error_code;
   logic [bmp_dec_pkg::DIM_W-1:0]     image_width;
   logic [bmp_dec_pkg::DIM_W-1:0]     image_height;
   logic [bmp_dec_pkg::INDEX_W-1:0]   pixel_index;
   logic [bmp_dec_pkg::COLOR_W-1:0]   red;
   logic [bmp_dec_pkg::COLOR_W-1:0]   green;
   logic [bmp_dec_pkg::COLOR_W-1:0]   blue;
   logic [bmp_dec_pkg::COLOR_W-1:0]   alpha;
   logic                              last_pixel;

   modport source (output valid, kind, error_code, image_width, image_height, pixel_index,
                   red, green, blue, alpha, last_pixel, input ready);
   modport sink (input valid, kind, error_code, image_width, image_height, pixel_index,
                 red, green, blue, alpha, last_pixel, output ready);
endinterface

### rtl/bmp_dec_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module bmp_dec_mul #(
   parameter int A_W = 15,
   parameter int B_W = 13
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     mcand,
   input  logic [B_W-1:0]     mplier,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W = A_W + B_W;
   localparam int C_W = $clog2(B_W + 1);

   logic [P_W-1:0] acc_ff, acc_in;
   logic [P_W-1:0] shift_ff, shift_in;
   logic [B_W-1:0] mplier_ff, mplier_in;
   logic [C_W-1:0] count_ff, count_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   // Load on start, then add the shifted multiplicand for each set multiplier bit.
   always_comb begin
      acc_in    = acc_ff;
      shift_in  = shift_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         shift_in  = P_W'(mcand);
         mplier_in = mplier;
         count_in  = C_W'(B_W);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + shift_ff;
         end
         shift_in  = shift_ff << 1;
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff - C_W'(1);
         if (count_ff == C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      shift_ff  <= shift_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### rtl/bmp_dec_csr.sv
// Register block holding the file size.
module bmp_dec_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  bmp_dec_pkg::apb_req_type            apb_req,
   output logic [bmp_dec_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                pready,
   output logic [31:0]                         file_size
);

   logic [31:0] file_size_ff, file_size_in;
   logic        reg_index;
   logic        wr_hit;

   assign reg_index = apb_req.paddr[bmp_dec_pkg::CSR_ADDR_W-1];
   assign wr_hit    = apb_req.psel && apb_req.penable && apb_req.pwrite &&
                      (reg_index == bmp_dec_pkg::REG_FILE_SIZE);

   // Write in the access phase; writes with the top address bit set are dropped.
   always_comb begin
      file_size_in = file_size_ff;
      if (wr_hit) begin
         file_size_in = apb_req.pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
      end else begin
         file_size_ff <= file_size_in;
      end
   end

   // Read data and a port that never waits.
   assign prdata    = (reg_index == bmp_dec_pkg::REG_FILE_SIZE) ? file_size_ff : '0;
   assign pready    = 1'b1;
   assign file_size = file_size_ff;

endmodule

### rtl/bmp_rgb24_stream_decoder.sv
// One byte per cycle whenever the result register is free and the header checks are not running;
// a result loaded by a byte is presented in the cycle after it. The last header byte (position 29)
// holds the input, when the early checks pass, for two passes of the shared shift-add multiplier.
// A failed early check on that byte does not hold the input.
// Synchronous active-high reset clears the sequencer, counters, result valid and file_size.
`include "bmp_rgb24_stream_decoder_macros.svh"

module bmp_rgb24_stream_decoder #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   bmp_dec_req_if.sink                         req_chan,
   bmp_dec_rsp_if.source                       rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bmp_dec_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bmp_dec_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bmp_dec_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int HB  = $clog2(MAX_HEIGHT + 1);
   localparam int RB  = WB + 2;
   localparam int PW  = RB + HB;
   localparam int SW  = ((PW > 32) ? PW : 32) + 1;

   localparam logic [1:0] PIX_BLUE  = 2'd0;
   localparam logic [1:0] PIX_GREEN = 2'd1;

   // Register port.
   bmp_dec_pkg::apb_req_type apb_req;
   logic [31:0]              file_size;

   assign apb_req = '{psel: csr_psel, penable: csr_penable, pwrite: csr_pwrite,
                      paddr: csr_paddr, pwdata: csr_pwdata};

   bmp_dec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .apb_req   (apb_req),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .file_size (file_size)
   );

   // State.
   logic [31:0]             pos_ff, pos_in;
   logic [31:0]             offset_ff, offset_in;
   logic [31:0]             raw_w_ff, raw_w_in;
   logic [31:0]             raw_h_ff, raw_h_in;
   logic [7:0]              depth_lo_ff, depth_lo_in;
   logic                    sig_ok_ff, sig_ok_in;
   logic [7:0]              held_blue_ff, held_blue_in;
   logic [7:0]              held_green_ff, held_green_in;
   logic [1:0]              pix_byte_ff, pix_byte_in;
   logic [RB-1:0]           row_byte_ff, row_byte_in;
   logic [WB-1:0]           col_ff, col_in;
   logic [HB-1:0]           row_ff, row_in;
   logic [23:0]             base_ff, base_in;
   logic                    eof_hold_ff, eof_hold_in;
   bmp_dec_pkg::phase_type  phase_ff, phase_in;
   bmp_dec_pkg::seq_type    seq_ff, seq_in;
   bmp_dec_pkg::rsp_type    rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Derived values.
   logic                    req_fire;
   logic                    rsp_free;
   logic                    rsp_load;
   logic [7:0]              byte_value;
   logic                    flip;
   logic [31:0]             hmag_full;
   logic [WB-1:0]           wid;
   logic [HB-1:0]           hmag;
   logic [RB-1:0]           row_bytes;
   logic [RB-1:0]           padded;
   logic [RB-1:0]           row_byte_nxt;
   logic                    pix_last;
   logic [1:0]              lane_off;
   logic [1:0]              lane_w;
   logic [1:0]              lane_h;
   logic                    dims_bad;
   logic                    hdr_fail;
   bmp_dec_pkg::err_type    hdr_code;
   logic                    data_fail;
   logic                    in_pixels;

   // Shared multiplier.
   logic                    mul_start;
   logic [RB-1:0]           mul_mcand;
   logic [HB-1:0]           mul_mplier;
   logic                    mul_done;
   logic [PW-1:0]           mul_product;

   bmp_dec_mul #(.A_W(RB), .B_W(HB)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   // Handshake.
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (seq_ff == bmp_dec_pkg::SEQ_RUN) && rsp_free;
   assign byte_value     = req_chan.byte_value;

   // Image geometry from the captured header.
   assign flip         = !raw_h_ff[31];
   assign hmag_full    = flip ? raw_h_ff : (32'd0 - raw_h_ff);
   assign wid          = raw_w_ff[WB-1:0];
   assign hmag         = hmag_full[HB-1:0];
   assign row_bytes    = {wid, 1'b0} + RB'(wid);
   assign padded       = (row_bytes + RB'(3)) & ~RB'(3);
   assign row_byte_nxt = row_byte_ff + RB'(1);
   assign pix_last     = ((WB+1)'(col_ff) + (WB+1)'(1) == (WB+1)'(wid)) &&
                         ((HB+1)'(row_ff) + (HB+1)'(1) == (HB+1)'(hmag));

   // Byte lane within each little-endian header word.
   assign lane_off = 2'(pos_ff - bmp_dec_pkg::POS_OFFSET);
   assign lane_w   = 2'(pos_ff - bmp_dec_pkg::POS_WIDTH);
   assign lane_h   = 2'(pos_ff - bmp_dec_pkg::POS_HEIGHT);

   // Header checks that need no multiplication, in priority order.
   assign dims_bad = (raw_w_ff == 32'd0) || raw_w_ff[31] || (raw_h_ff == 32'd0) ||
                     (raw_w_ff > 32'(MAX_WIDTH)) || (hmag_full > 32'(MAX_HEIGHT));

   always_comb begin
      hdr_fail = 1'b1;
      hdr_code = bmp_dec_pkg::ERR_SHORT;
      if (file_size < bmp_dec_pkg::MIN_FILE_SIZE) begin
         hdr_code = bmp_dec_pkg::ERR_SHORT;
      end else if (!sig_ok_ff) begin
         hdr_code = bmp_dec_pkg::ERR_SIGNATURE;
      end else if (offset_ff >= file_size) begin
         hdr_code = bmp_dec_pkg::ERR_OFFSET_END;
      end else if (offset_ff < bmp_dec_pkg::FIRST_PIXEL_POS) begin
         hdr_code = bmp_dec_pkg::ERR_OFFSET_HDR;
      end else if (dims_bad) begin
         hdr_code = bmp_dec_pkg::ERR_DIMENSIONS;
      end else if ({byte_value, depth_lo_ff} != bmp_dec_pkg::DEPTH_RGB24) begin
         hdr_code = bmp_dec_pkg::ERR_DEPTH;
      end else begin
         hdr_fail = 1'b0;
      end
   end

   // Pixel data must end inside the file.
   assign data_fail = (SW'(offset_ff) + SW'(mul_product)) > SW'(file_size);

   assign in_pixels = (phase_ff == bmp_dec_pkg::PH_PIXELS) ||
                      ((phase_ff == bmp_dec_pkg::PH_SKIP) && (pos_ff >= offset_ff));

   // Byte handling and header check sequencer.
   always_comb begin
      pos_in        = pos_ff;
      offset_in     = offset_ff;
      raw_w_in      = raw_w_ff;
      raw_h_in      = raw_h_ff;
      depth_lo_in   = depth_lo_ff;
      sig_ok_in     = sig_ok_ff;
      held_blue_in  = held_blue_ff;
      held_green_in = held_green_ff;
      pix_byte_in   = pix_byte_ff;
      row_byte_in   = row_byte_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      eof_hold_in   = eof_hold_ff;
      phase_in      = phase_ff;
      seq_in        = seq_ff;
      rsp_in        = rsp_ff;
      rsp_load      = 1'b0;
      mul_start     = 1'b0;
      mul_mcand     = padded;
      mul_mplier    = hmag;

      case (seq_ff)
         bmp_dec_pkg::SEQ_RUN: begin
            if (req_fire) begin
               if (phase_ff == bmp_dec_pkg::PH_HEADER) begin
                  // Capture header fields by position.
                  if (pos_ff == bmp_dec_pkg::POS_SIG_B) begin
                     sig_ok_in = (byte_value == bmp_dec_pkg::SIG_B);
                  end else if (pos_ff == bmp_dec_pkg::POS_SIG_M) begin
                     sig_ok_in = sig_ok_ff && (byte_value == bmp_dec_pkg::SIG_M);
                  end else if (pos_ff inside {[bmp_dec_pkg::POS_OFFSET :
                                               bmp_dec_pkg::POS_OFFSET_END]}) begin
                     offset_in[{lane_off, 3'b000} +: 8] = byte_value;
                  end else if (pos_ff inside {[bmp_dec_pkg::POS_WIDTH :
                                               bmp_dec_pkg::POS_WIDTH_END]}) begin
                     raw_w_in[{lane_w, 3'b000} +: 8] = byte_value;
                  end else if (pos_ff inside {[bmp_dec_pkg::POS_HEIGHT :
                                               bmp_dec_pkg::POS_HEIGHT_END]}) begin
                     raw_h_in[{lane_h, 3'b000} +: 8] = byte_value;
                  end else if (pos_ff == bmp_dec_pkg::POS_DEPTH) begin
                     depth_lo_in = byte_value;
                  end

                  // Last header byte: report an early failure or start the size product.
                  if (pos_ff == bmp_dec_pkg::HEADER_LAST) begin
                     if (hdr_fail) begin
                        rsp_load          = 1'b1;
                        rsp_in            = '0;
                        rsp_in.kind       = bmp_dec_pkg::KIND_ERROR;
                        rsp_in.error_code = hdr_code;
                        phase_in          = bmp_dec_pkg::PH_DONE;
                     end else begin
                        mul_start   = 1'b1;
                        eof_hold_in = req_chan.end_of_file;
                        seq_in      = bmp_dec_pkg::SEQ_SIZE;
                     end
                  end
               end else if (in_pixels) begin
                  phase_in = bmp_dec_pkg::PH_PIXELS;
                  // Gather blue, green, red and emit on red.
                  if (row_byte_ff < row_bytes) begin
                     case (pix_byte_ff)
                        PIX_BLUE: begin
                           held_blue_in = byte_value;
                           pix_byte_in  = PIX_GREEN;
                        end
                        PIX_GREEN: begin
                           held_green_in = byte_value;
                           pix_byte_in   = PIX_GREEN + 2'd1;
                        end
                        default: begin
                           rsp_load           = 1'b1;
                           rsp_in             = '0;
                           rsp_in.kind        = bmp_dec_pkg::KIND_PIXEL;
                           rsp_in.pixel_index = base_ff + 24'(col_ff);
                           rsp_in.red         = byte_value;
                           rsp_in.green       = held_green_ff;
                           rsp_in.blue        = held_blue_ff;
                           rsp_in.alpha       = bmp_dec_pkg::ALPHA_OPAQUE;
                           rsp_in.last_pixel  = pix_last;
                           pix_byte_in        = PIX_BLUE;
                           col_in             = col_ff + WB'(1);
                           if (pix_last) begin
                              phase_in = bmp_dec_pkg::PH_DONE;
                           end
                        end
                     endcase
                  end
                  // Row bookkeeping, padding dropped at the row end.
                  if (!(rsp_load && pix_last)) begin
                     row_byte_in = row_byte_nxt;
                     if (row_byte_nxt >= padded) begin
                        row_byte_in = '0;
                        pix_byte_in = PIX_BLUE;
                        col_in      = '0;
                        row_in      = row_ff + HB'(1);
                        base_in     = flip ? (base_ff - 24'(wid)) : (base_ff + 24'(wid));
                        if ((HB+1)'(row_ff) + (HB+1)'(1) >= (HB+1)'(hmag)) begin
                           phase_in = bmp_dec_pkg::PH_DONE;
                        end
                     end
                  end
               end

               pos_in = pos_ff + 32'd1;

               // End of file: report a truncated header, then start over.
               if (req_chan.end_of_file) begin
                  if ((phase_ff == bmp_dec_pkg::PH_HEADER) &&
                      (pos_ff != bmp_dec_pkg::HEADER_LAST)) begin
                     rsp_load          = 1'b1;
                     rsp_in            = '0;
                     rsp_in.kind       = bmp_dec_pkg::KIND_ERROR;
                     rsp_in.error_code = bmp_dec_pkg::ERR_SHORT;
                  end
                  pos_in      = '0;
                  phase_in    = bmp_dec_pkg::PH_HEADER;
                  pix_byte_in = PIX_BLUE;
                  row_byte_in = '0;
                  col_in      = '0;
                  row_in      = '0;
               end
            end
         end

         bmp_dec_pkg::SEQ_SIZE: begin
            // Size product ready: check it, then compute the first row base.
            if (mul_done) begin
               if (data_fail) begin
                  rsp_load          = 1'b1;
                  rsp_in            = '0;
                  rsp_in.kind       = bmp_dec_pkg::KIND_ERROR;
                  rsp_in.error_code = bmp_dec_pkg::ERR_DATA_END;
                  if (!eof_hold_ff) begin
                     phase_in = bmp_dec_pkg::PH_DONE;
                  end
                  seq_in = bmp_dec_pkg::SEQ_RUN;
               end else begin
                  mul_start  = 1'b1;
                  mul_mcand  = RB'(wid);
                  mul_mplier = hmag - HB'(1);
                  seq_in     = bmp_dec_pkg::SEQ_BASE;
               end
            end
         end

         bmp_dec_pkg::SEQ_BASE: begin
            // Bottom-up images start writing at the last destination row.
            if (mul_done) begin
               base_in             = flip ? 24'(mul_product) : 24'd0;
               rsp_load            = 1'b1;
               rsp_in              = '0;
               rsp_in.kind         = bmp_dec_pkg::KIND_HEADER;
               rsp_in.image_width  = bmp_dec_pkg::dim_type'(wid);
               rsp_in.image_height = bmp_dec_pkg::dim_type'(hmag);
               if (!eof_hold_ff) begin
                  phase_in = bmp_dec_pkg::PH_SKIP;
               end
               seq_in = bmp_dec_pkg::SEQ_RUN;
            end
         end

         default: begin
            seq_in = bmp_dec_pkg::SEQ_RUN;
         end
      endcase
   end

   // Result valid: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pix_byte_ff  <= PIX_BLUE;
         row_byte_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         eof_hold_ff  <= 1'b0;
         phase_ff     <= bmp_dec_pkg::PH_HEADER;
         seq_ff       <= bmp_dec_pkg::SEQ_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         pix_byte_ff  <= pix_byte_in;
         row_byte_ff  <= row_byte_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         eof_hold_ff  <= eof_hold_in;
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Header fields, held colors, row base and result payload.
   always_ff @(posedge clock) begin
      offset_ff     <= offset_in;
      raw_w_ff      <= raw_w_in;
      raw_h_ff      <= raw_h_in;
      depth_lo_ff   <= depth_lo_in;
      sig_ok_ff     <= sig_ok_in;
      held_blue_ff  <= held_blue_in;
      held_green_ff <= held_green_in;
      base_ff       <= base_in;
      rsp_ff        <= rsp_in;
   end

   // Result channel.
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_ff.kind;
   assign rsp_chan.error_code   = rsp_ff.error_code;
   assign rsp_chan.image_width  = rsp_ff.image_width;
   assign rsp_chan.image_height = rsp_ff.image_height;
   assign rsp_chan.pixel_index  = rsp_ff.pixel_index;
   assign rsp_chan.red          = rsp_ff.red;
   assign rsp_chan.green        = rsp_ff.green;
   assign rsp_chan.blue         = rsp_ff.blue;
   assign rsp_chan.alpha        = rsp_ff.alpha;
   assign rsp_chan.last_pixel   = rsp_ff.last_pixel;

   // A new result never lands on one that is still waiting.
   `BMP_ASSERT_SAME(a_rsp_no_overwrite, clock, reset, rsp_load, rsp_free, "result overwritten")
   // The multiplier finishes only while the sequencer waits for it.
   `BMP_ASSERT_SAME(a_mul_done_expected, clock, reset, mul_done, (seq_ff == bmp_dec_pkg::SEQ_SIZE) || (seq_ff == bmp_dec_pkg::SEQ_BASE), "stray multiplier result")
   // Emitted pixels stay inside the image.
   `BMP_ASSERT_SAME(a_pixel_in_image, clock, reset, rsp_load && (rsp_in.kind == bmp_dec_pkg::KIND_PIXEL), ((WB+1)'(col_ff) < (WB+1)'(wid)) && (row_ff < hmag), "pixel outside image")
   // A loaded result is presented in the next cycle.
   `BMP_ASSERT_NEXT(a_rsp_presented, clock, reset, rsp_load, rsp_valid_ff, "loaded result not presented")

endmodule

### verif/tb_bmp_rgb24_stream_decoder.sv
module tb_bmp_rgb24_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import bmp_dec_pkg::*;

   localparam int MAX_W = 4096;
   localparam int MAX_H = 4096;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT = 1000;
   localparam int RANDOM_BYTES = 500;
   localparam int PRINT_CAP = 30;
   localparam logic [CSR_ADDR_W-1:0] FILE_SIZE_ADDR = CSR_ADDR_W'(4 * REG_FILE_SIZE);

   typedef struct packed {
      logic [7:0] value;
      logic       last_byte;
   } file_byte_type;

   logic clock = 1'b0;
   logic reset;

   bmp_dec_req_if req_chan();
   bmp_dec_rsp_if rsp_chan();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bmp_rgb24_stream_decoder #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5ns clock = ~clock;

   // Stimulus and expectation stores.
   file_byte_type byte_queue[$];
   rsp_type       due_results[$];
   logic [7:0]    file_img[$];

   int  fail_count = 0;
   int  quiet_cycles = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   bit  src_calm = 1'b0;
   bit  snk_calm = 1'b0;
   file_byte_type next_byte;

   // Decoder state as the predictor tracks it.
   logic [31:0] size_reg;
   logic [31:0] pos;
   logic [31:0] poff;
   logic [31:0] rwid;
   logic [31:0] rhgt;
   logic [15:0] depth;
   bit          flip;
   bit          sig_ok;
   logic [7:0]  held_b;
   logic [7:0]  held_g;
   logic [31:0] pix_byte;
   logic [31:0] row_byte;
   logic [31:0] col;
   logic [31:0] row;
   phase_type   ph;

   function automatic void clear_decoder();
      pos = '0;
      poff = '0;
      rwid = '0;
      rhgt = '0;
      depth = '0;
      flip = 1'b0;
      sig_ok = 1'b0;
      held_b = '0;
      held_g = '0;
      pix_byte = '0;
      row_byte = '0;
      col = '0;
      row = '0;
      ph = PH_HEADER;
   endfunction

   function automatic logic [31:0] height_mag();
      return flip ? rhgt : 32'd0 - rhgt;
   endfunction

   // Header checks in their fixed order; returns 1 when the header is accepted.
   function automatic bit screen_header(output err_type code);
      logic [31:0] h;
      logic [63:0] row_bytes;
      code = ERR_SHORT;
      if (size_reg < MIN_FILE_SIZE) return 1'b0;
      code = ERR_SIGNATURE;
      if (!sig_ok) return 1'b0;
      code = ERR_OFFSET_END;
      if (poff >= size_reg) return 1'b0;
      code = ERR_OFFSET_HDR;
      if (poff < FIRST_PIXEL_POS) return 1'b0;
      flip = !rhgt[31];
      h = height_mag();
      code = ERR_DIMENSIONS;
      if (rwid == 0 || rwid[31] || rhgt == 0) return 1'b0;
      if (rwid > MAX_W || h > MAX_H) return 1'b0;
      code = ERR_DEPTH;
      if (depth != DEPTH_RGB24) return 1'b0;
      row_bytes = (64'(rwid) * 64'd3 + 64'd3) & ~64'd3;
      code = ERR_DATA_END;
      if (64'(poff) + row_bytes * 64'(h) > 64'(size_reg)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit take_header_byte(input logic [31:0] p, input logic [7:0] v,
                                           output rsp_type r);
      err_type code;
      r = '0;
      if (p == POS_SIG_B) sig_ok = (v == SIG_B);
      else if (p == POS_SIG_M) sig_ok = sig_ok && (v == SIG_M);
      else if (p >= POS_OFFSET && p <= POS_OFFSET_END)
         poff |= 32'(v) << (8 * (p - POS_OFFSET));
      else if (p >= POS_WIDTH && p <= POS_WIDTH_END)
         rwid |= 32'(v) << (8 * (p - POS_WIDTH));
      else if (p >= POS_HEIGHT && p <= POS_HEIGHT_END)
         rhgt |= 32'(v) << (8 * (p - POS_HEIGHT));
      else if (p == POS_DEPTH || p == HEADER_LAST)
         depth |= 16'(16'(v) << (8 * (p - POS_DEPTH)));
      if (p != HEADER_LAST) return 1'b0;
      if (screen_header(code)) begin
         ph = PH_SKIP;
         r.kind = KIND_HEADER;
         r.image_width = DIM_W'(rwid);
         r.image_height = DIM_W'(height_mag());
      end else begin
         ph = PH_DONE;
         r.kind = KIND_ERROR;
         r.error_code = code;
      end
      return 1'b1;
   endfunction

   // One byte of pixel data: blue, green, red, then row padding.
   function automatic bit take_pixel_byte(input logic [7:0] v, output rsp_type r);
      logic [31:0] h;
      logic [31:0] raw_row;
      logic [31:0] padded;
      logic [31:0] dest;
      bit          got;
      bit          final_pix;
      r = '0;
      got = 1'b0;
      h = height_mag();
      raw_row = rwid * 3;
      padded = (raw_row + 3) & ~32'd3;
      if (row_byte < raw_row) begin
         if (pix_byte == 0) begin
            held_b = v;
            pix_byte = 1;
         end else if (pix_byte == 1) begin
            held_g = v;
            pix_byte = 2;
         end else begin
            dest = flip ? h - 1 - row : row;
            final_pix = (col + 1 == rwid) && (row + 1 == h);
            r.kind = KIND_PIXEL;
            r.pixel_index = INDEX_W'(dest * rwid + col);
            r.red = v;
            r.green = held_g;
            r.blue = held_b;
            r.alpha = ALPHA_OPAQUE;
            r.last_pixel = final_pix;
            got = 1'b1;
            pix_byte = 0;
            col = col + 1;
            if (final_pix) begin
               ph = PH_DONE;
               return got;
            end
         end
      end
      row_byte = row_byte + 1;
      if (row_byte >= padded) begin
         row_byte = 0;
         pix_byte = 0;
         col = 0;
         row = row + 1;
         if (row >= h) ph = PH_DONE;
      end
      return got;
   endfunction

   // Works out the result of one accepted byte and queues it.
   function automatic void predict_byte(input logic [7:0] v, input logic eof);
      rsp_type r;
      bit      got;
      r = '0;
      got = 1'b0;
      if (ph == PH_HEADER) begin
         got = take_header_byte(pos, v, r);
      end else begin
         if (ph == PH_SKIP && pos >= poff) ph = PH_PIXELS;
         if (ph == PH_PIXELS) got = take_pixel_byte(v, r);
      end
      pos = pos + 1;
      if (eof) begin
         if (!got && ph == PH_HEADER) begin
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = ERR_SHORT;
            got = 1'b1;
         end
         clear_decoder();
      end
      if (got) due_results.push_back(r);
   endfunction

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_result();
      rsp_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result of kind %0d with none expected", rsp_chan.kind));
         return;
      end
      want = due_results.pop_front();
      compare_field("kind", rsp_chan.kind, want.kind);
      compare_field("error_code", rsp_chan.error_code, want.error_code);
      compare_field("image_width", rsp_chan.image_width, want.image_width);
      compare_field("image_height", rsp_chan.image_height, want.image_height);
      compare_field("pixel_index", rsp_chan.pixel_index, want.pixel_index);
      compare_field("red", rsp_chan.red, want.red);
      compare_field("green", rsp_chan.green, want.green);
      compare_field("blue", rsp_chan.blue, want.blue);
      compare_field("alpha", rsp_chan.alpha, want.alpha);
      compare_field("last_pixel", rsp_chan.last_pixel, want.last_pixel);
   endtask

   // Byte driver: predicts each accepted transaction, then offers the next after a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_byte(req_chan.byte_value, req_chan.end_of_file);
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               next_byte = byte_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.byte_value <= next_byte.value;
               req_chan.end_of_file <= next_byte.last_byte;
               gap_left = draw_gap(src_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_result();
            stall_left = draw_gap(snk_calm);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bmp_rgb24_stream_decoder verification failed");
            $finish;
         end
      end
   end

   // Waits until every byte is taken and every result has come, then lets the block settle.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_chan.valid || due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_file_size(input logic [31:0] value);
      wait_for_drain();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= FILE_SIZE_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      size_reg = value;
   endtask

   // Fills the image buffer with a 30-byte header; unused positions get random filler.
   task automatic build_header(input logic [31:0] offset, input logic [31:0] width,
                               input logic [31:0] height, input logic [15:0] bpp,
                               input int sig_fault);
      logic [7:0] b;
      file_img.delete();
      for (int i = 0; i <= HEADER_LAST; i++) begin
         b = 8'($urandom_range(0, 255));
         if (i == POS_SIG_B)
            b = (sig_fault == 1) ? SIG_B ^ 8'($urandom_range(1, 255)) : SIG_B;
         else if (i == POS_SIG_M)
            b = (sig_fault == 2) ? SIG_M ^ 8'($urandom_range(1, 255)) : SIG_M;
         else if (i >= POS_OFFSET && i <= POS_OFFSET_END)
            b = offset[8 * (i - POS_OFFSET) +: 8];
         else if (i >= POS_WIDTH && i <= POS_WIDTH_END)
            b = width[8 * (i - POS_WIDTH) +: 8];
         else if (i >= POS_HEIGHT && i <= POS_HEIGHT_END)
            b = height[8 * (i - POS_HEIGHT) +: 8];
         else if (i >= POS_DEPTH)
            b = bpp[8 * (i - POS_DEPTH) +: 8];
         file_img.push_back(b);
      end
   endtask

   task automatic add_bytes(input int count);
      repeat (count) file_img.push_back(8'($urandom_range(0, 255)));
   endtask

   // Queues the image buffer as one file, the final byte flagged as end of file.
   task automatic send_file(input bit rewrite, input logic [31:0] size, input bit brisk);
      if (rewrite) program_file_size(size);
      src_calm = brisk || ($urandom_range(0, 3) == 0);
      snk_calm = brisk || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < file_img.size(); i++)
         byte_queue.push_back('{value: file_img[i], last_byte: (i == file_img.size() - 1)});
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int          natural_len;
      int          body;
      int          pick;
      int          random_total;
      bit          rewrite;
      int          sig;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] offset;
      logic [31:0] size;
      logic [15:0] bpp;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.byte_value = '0;
      req_chan.end_of_file = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      size_reg = '0;
      clear_decoder();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Early end: a single byte, then an end inside the header.
      file_img.delete();
      add_bytes(1);
      send_file(1'b1, 32'd0, 1'b0);
      build_header(32'd30, 32'd2, 32'd2, DEPTH_RGB24, 0);
      file_img = file_img[0:11];
      send_file(1'b1, 32'd200, 1'b0);

      // File size below the minimum, and at the minimum with the offset past the end.
      build_header(32'd54, 32'd2, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b1, 32'd13, 1'b0);
      build_header(32'd54, 32'd2, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b1, 32'd14, 1'b0);

      // Bad signature in either byte.
      build_header(32'd30, 32'd2, 32'd2, DEPTH_RGB24, 1);
      send_file(1'b1, 32'd100, 1'b0);
      build_header(32'd30, 32'd2, 32'd2, DEPTH_RGB24, 2);
      send_file(1'b0, 32'd100, 1'b0);

      // Offset equal to the file size, and offsets inside the header.
      build_header(32'd100, 32'd2, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b0, 32'd100, 1'b0);
      build_header(32'd29, 32'd2, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b0, 32'd100, 1'b0);
      build_header(32'd0, 32'd2, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b0, 32'd100, 1'b0);

      // Bad dimensions: zero, negative and oversized width or height.
      build_header(32'd30, 32'd0, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b1, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'h8000_0000, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'd2, 32'd0, DEPTH_RGB24, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'd4097, 32'd1, DEPTH_RGB24, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'd1, 32'd4097, DEPTH_RGB24, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'd1, 32'hFFFF_EFFF, DEPTH_RGB24, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'd1, 32'h8000_0000, DEPTH_RGB24, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);

      // Depth other than 24, including one that differs only in the high byte.
      build_header(32'd30, 32'd1, 32'd1, 16'd32, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'd1, 32'd1, 16'h0118, 0);
      send_file(1'b0, 32'hFFFF_FFFF, 1'b0);

      // Pixel data past the end, by one byte and by a huge offset.
      build_header(32'd30, 32'd3, 32'd2, DEPTH_RGB24, 0);
      add_bytes(24);
      send_file(1'b1, 32'd53, 1'b0);
      build_header(32'hFFFF_FFFE, 32'd1, 32'd1, DEPTH_RGB24, 0);
      send_file(1'b1, 32'hFFFF_FFFF, 1'b0);

      // Bottom-up image with skipped bytes, padding and trailing bytes.
      build_header(32'd34, 32'd3, 32'd2, DEPTH_RGB24, 0);
      add_bytes(4 + 24 + 5);
      send_file(1'b1, 32'd58, 1'b0);

      // Top-down single pixel, a stream cut inside the pixel data, and an end on the last
      // header byte.
      build_header(32'd30, 32'd1, 32'hFFFF_FFFF, DEPTH_RGB24, 0);
      add_bytes(3);
      send_file(1'b1, 32'hFFFF_FFFF, 1'b0);
      build_header(32'd30, 32'd2, 32'd3, DEPTH_RGB24, 0);
      add_bytes(10);
      send_file(1'b1, 32'd54, 1'b0);
      build_header(32'd30, 32'd2, 32'd2, DEPTH_RGB24, 0);
      send_file(1'b1, 32'd100, 1'b0);

      // Largest images: a full widest row, and the first pixels of the tallest image.
      build_header(32'd30, 32'd4096, 32'hFFFF_FFFF, DEPTH_RGB24, 0);
      add_bytes(4096 * 3 + 2);
      send_file(1'b1, 32'hFFFF_FFFF, 1'b1);
      build_header(32'd30, 32'd4096, 32'd4096, DEPTH_RGB24, 0);
      add_bytes(300);
      send_file(1'b1, 32'hFFFF_FFFF, 1'b0);

      // Random files: mostly well formed, some with one broken header field, some noise.
      random_total = 0;
      while (random_total < RANDOM_BYTES) begin
         w = $urandom_range(1, 4);
         h = $urandom_range(1, 3);
         width = w;
         height = $urandom_range(0, 1) ? 32'd0 - h : 32'(h);
         offset = 30 + $urandom_range(0, 3);
         bpp = DEPTH_RGB24;
         sig = 0;
         natural_len = offset + ((w * 3 + 3) & ~3) * h;
         size = natural_len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
         body = natural_len - 30;
         rewrite = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 92) begin
            if (pick < 65) begin
               if ($urandom_range(0, 5) == 0) body = $urandom_range(0, body - 1);
               else if ($urandom_range(0, 3) == 0) body += $urandom_range(1, 6);
            end else begin
               body = $urandom_range(0, 6);
               case ($urandom_range(0, 7))
                  0: sig = $urandom_range(1, 2);
                  1: size = $urandom_range(0, 13);
                  2: size = $urandom_range(14, offset);
                  3: offset = $urandom_range(0, 29);
                  4: begin
                     case ($urandom_range(0, 2))
                        0: width = 32'd0;
                        1: width = {1'b1, 31'($urandom)};
                        default: width = $urandom_range(MAX_W + 1, 65535);
                     endcase
                  end
                  5: begin
                     case ($urandom_range(0, 3))
                        0: height = 32'd0;
                        1: height = 32'h8000_0000;
                        2: height = $urandom_range(MAX_H + 1, 65535);
                        default: height = 32'd0 - $urandom_range(MAX_H + 1, 65535);
                     endcase
                  end
                  6: begin
                     bpp = 16'($urandom);
                     if (bpp == DEPTH_RGB24) bpp = 16'd32;
                  end
                  default: size = natural_len - $urandom_range(1, natural_len - offset);
               endcase
               rewrite = 1'b1;
            end
            build_header(offset, width, height, bpp, sig);
            add_bytes(body);
         end else begin
            file_img.delete();
            add_bytes($urandom_range(1, 45));
            if (file_img.size() >= 2 && $urandom_range(0, 1)) begin
               file_img[0] = SIG_B;
               file_img[1] = SIG_M;
            end
            size = $urandom;
         end
         random_total += file_img.size();
         send_file(rewrite, size, 1'b0);
      end

      wait_for_drain();
      if (fail_count == 0) begin
         $display("bmp_rgb24_stream_decoder verification clean");
      end else begin
         $display("bmp_rgb24_stream_decoder verification failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/bmp_dec_pkg.sv
rtl/bmp_dec_ifs.sv
rtl/bmp_dec_mul.sv
rtl/bmp_dec_csr.sv
rtl/bmp_rgb24_stream_decoder.sv
verif/tb_bmp_rgb24_stream_decoder.sv
